FILE: design/gsp_pkg.sv
// Package for the grid shortest path engine.
// Holds the operation codes, configuration register indexes and neighbor direction codes; no dependencies.
package gsp_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_RUN  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

endpackage

FILE: design/grid_shortest_path_engine.sv
// Least-cost path search on a 4-neighbor pixel grid, from pixel 0 to the last pixel.
// A load request is answered straight from idle and a read request through ST_PREAD.
// A run request first clears the node memory, then for every settled pixel sweeps the
// whole node memory to find the least (distance, index) pixel and relaxes its four
// neighbors; the path is then traced back from the last pixel. Ties settle the lowest
// pixel index. Each sweep reads through the single read port of the node memory.
// Depends on gsp_pkg.
module grid_shortest_path_engine #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int COST_BITS  = 16,
  parameter int DIST_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [11:0] pixel_or_position_i,
  input  logic [15:0] cost_left_i,
  input  logic [15:0] cost_up_i,
  input  logic [15:0] cost_right_i,
  input  logic [15:0] cost_down_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [31:0] total_cost_o,
  output logic [12:0] path_length_o,
  output logic [11:0] path_pixel_o
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int PB   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int LB   = $clog2(NPIX + 1);
  localparam int WB   = $clog2(MAX_WIDTH + 1);
  localparam int HB   = $clog2(MAX_HEIGHT + 1);
  localparam int CB   = COST_BITS;
  localparam int DB   = DIST_BITS;
  localparam int NW   = DB + 2;
  localparam int SW   = ((DB > CB) ? DB : CB) + 1;
  localparam logic [DB-1:0] DIST_MAX = {DB{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREAD, ST_CLR, ST_INIT, ST_NEXT, ST_SCAN, ST_SETTLE, ST_REL_RD, ST_REL_WR,
    ST_LEN_RD, ST_LEN_WT, ST_PATH_RD, ST_PATH_WT
  } state_e;

  state_e state_q;

  // Memories. A node word holds reached, settled and the distance.
  logic [4*CB-1:0] cost_mem [NPIX];
  logic [NW-1:0]   node_mem [NPIX];
  logic [PB-1:0]   parent_mem [NPIX];
  logic [PB-1:0]   path_mem [NPIX];

  logic [4*CB-1:0] cost_rdata_q;
  logic [NW-1:0]   node_rdata_q;
  logic [PB-1:0]   parent_rdata_q;
  logic [PB-1:0]   path_rdata_q;

  logic            cost_we;
  logic            node_we, parent_we, path_we;
  logic [PB-1:0]   node_waddr, node_raddr, parent_waddr, path_waddr;
  logic [NW-1:0]   node_wdata;
  logic [PB-1:0]   parent_wdata, path_wdata;

  logic [6:0]      gw_q, gh_q;
  logic [WB-1:0]   w_eff, w_q, sx_q, x1_q, bx_q;
  logic [HB-1:0]   h_eff, h_q, sy_q, y1_q, by_q;
  logic [LB-1:0]   n_q, idx_q, len_q, found_len_q;
  logic [PB-1:0]   goal_q, i1_q, bp_q, to_q, cur_q;
  logic            v1_q, found_q;
  logic [DB-1:0]   best_q, found_cost_q;
  logic [1:0]      dir_q;
  logic [11:0]     pos_q;
  logic            out_valid_q, status_q;
  logic [11:0]     pixel_q;

  logic            acc;
  logic            dir_ok;
  logic [PB-1:0]   to_pix;
  logic [CB-1:0]   step_cost;
  logic [SW-1:0]   sum;
  logic [DB-1:0]   cand;
  logic [63:0]     fc64;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);

  always_comb begin
    if (gw_q == 7'd0) w_eff = WB'(1);
    else if (32'(gw_q) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
    else w_eff = WB'(gw_q);
    if (gh_q == 7'd0) h_eff = HB'(1);
    else if (32'(gh_q) > MAX_HEIGHT) h_eff = HB'(MAX_HEIGHT);
    else h_eff = HB'(gh_q);
  end

  // Neighbor of the settled pixel in the current direction.
  always_comb begin
    dir_ok = 1'b0;
    to_pix = bp_q;
    case (dir_q)
      gsp_pkg::DIR_LEFT: begin
        dir_ok = (bx_q != '0);
        to_pix = PB'(32'(bp_q) - 32'd1);
      end
      gsp_pkg::DIR_UP: begin
        dir_ok = (by_q != '0);
        to_pix = PB'(32'(bp_q) - 32'(w_q));
      end
      gsp_pkg::DIR_RIGHT: begin
        dir_ok = (32'(bx_q) + 32'd1 < 32'(w_q));
        to_pix = PB'(32'(bp_q) + 32'd1);
      end
      gsp_pkg::DIR_DOWN: begin
        dir_ok = (32'(by_q) + 32'd1 < 32'(h_q));
        to_pix = PB'(32'(bp_q) + 32'(w_q));
      end
      default: begin
        dir_ok = 1'b0;
        to_pix = bp_q;
      end
    endcase
  end

  assign step_cost = cost_rdata_q[32'(dir_q)*CB +: CB];
  assign sum  = SW'(best_q) + SW'(step_cost);
  assign cand = (sum > SW'(DIST_MAX)) ? DIST_MAX : DB'(sum);

  // Memory port control.
  always_comb begin
    cost_we      = 1'b0;
    node_we      = 1'b0;
    node_waddr   = PB'(idx_q);
    node_wdata   = '0;
    node_raddr   = PB'(idx_q);
    parent_we    = 1'b0;
    parent_waddr = to_q;
    parent_wdata = bp_q;
    path_we      = 1'b0;
    path_waddr   = PB'(LB'(idx_q - LB'(1)));
    path_wdata   = cur_q;
    case (state_q)
      ST_IDLE: begin
        cost_we = acc && (op_i == gsp_pkg::OP_LOAD) && (32'(pixel_or_position_i) < NPIX);
      end
      ST_CLR: begin
        node_we = 1'b1;
      end
      ST_INIT: begin
        node_we      = 1'b1;
        node_waddr   = '0;
        node_wdata   = {1'b1, 1'b0, {DB{1'b0}}};
        parent_we    = 1'b1;
        parent_waddr = '0;
        parent_wdata = '0;
      end
      ST_SETTLE: begin
        node_we    = 1'b1;
        node_waddr = bp_q;
        node_wdata = {1'b1, 1'b1, best_q};
      end
      ST_REL_RD: begin
        node_raddr = to_pix;
      end
      ST_REL_WR: begin
        if (!node_rdata_q[DB] && (!node_rdata_q[DB+1] || cand < node_rdata_q[DB-1:0])) begin
          node_we    = 1'b1;
          node_waddr = to_q;
          node_wdata = {1'b1, 1'b0, cand};
          parent_we  = 1'b1;
        end
      end
      ST_PATH_RD: begin
        path_we = 1'b1;
      end
      default: begin
        cost_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem[PB'(pixel_or_position_i)] <= {CB'(cost_down_i), CB'(cost_right_i),
                                             CB'(cost_up_i), CB'(cost_left_i)};
    end
    cost_rdata_q <= cost_mem[bp_q];
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata_q <= node_mem[node_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= parent_wdata;
    end
    parent_rdata_q <= parent_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (path_we) begin
      path_mem[path_waddr] <= path_wdata;
    end
    path_rdata_q <= path_mem[PB'(pixel_or_position_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      gw_q         <= 7'd64;
      gh_q         <= 7'd64;
      found_len_q  <= '0;
      found_cost_q <= '0;
      out_valid_q  <= 1'b0;
      v1_q         <= 1'b0;
      found_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == gsp_pkg::CFG_GRID_WIDTH) gw_q <= cfg_data_i;
        else gh_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            pos_q <= pixel_or_position_i;
            if (op_i == gsp_pkg::OP_RUN) begin
              w_q     <= w_eff;
              h_q     <= h_eff;
              n_q     <= LB'(32'(w_eff) * 32'(h_eff));
              idx_q   <= '0;
              state_q <= ST_CLR;
            end else if (op_i == gsp_pkg::OP_READ) begin
              state_q <= ST_PREAD;
            end else begin
              out_valid_q <= 1'b1;
              status_q    <= 1'b0;
              pixel_q     <= '0;
            end
          end
        end
        ST_PREAD: begin
          out_valid_q <= 1'b1;
          if (32'(pos_q) < 32'(found_len_q)) begin
            status_q <= 1'b0;
            pixel_q  <= 12'(path_rdata_q);
          end else begin
            status_q <= 1'b1;
            pixel_q  <= '0;
          end
          state_q <= ST_IDLE;
        end
        ST_CLR: begin
          goal_q <= PB'(LB'(n_q - LB'(1)));
          if (idx_q == LB'(n_q - LB'(1))) state_q <= ST_INIT;
          idx_q <= LB'(idx_q + LB'(1));
        end
        // The start pixel is seeded only once; later sweeps start from ST_NEXT.
        ST_INIT, ST_NEXT: begin
          idx_q   <= '0;
          sx_q    <= '0;
          sy_q    <= '0;
          v1_q    <= 1'b0;
          found_q <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (idx_q < n_q) begin
            v1_q  <= 1'b1;
            i1_q  <= PB'(idx_q);
            x1_q  <= sx_q;
            y1_q  <= sy_q;
            idx_q <= LB'(idx_q + LB'(1));
            if (WB'(sx_q + WB'(1)) == w_q) begin
              sx_q <= '0;
              sy_q <= HB'(sy_q + HB'(1));
            end else begin
              sx_q <= WB'(sx_q + WB'(1));
            end
          end else begin
            v1_q <= 1'b0;
          end
          if (v1_q && node_rdata_q[DB+1] && !node_rdata_q[DB]
              && (!found_q || node_rdata_q[DB-1:0] < best_q)) begin
            found_q <= 1'b1;
            best_q  <= node_rdata_q[DB-1:0];
            bp_q    <= i1_q;
            bx_q    <= x1_q;
            by_q    <= y1_q;
          end
          if (idx_q == n_q && !v1_q) begin
            if (found_q) begin
              state_q <= ST_SETTLE;
            end else begin
              cur_q   <= goal_q;
              len_q   <= LB'(1);
              state_q <= ST_LEN_RD;
            end
          end
        end
        ST_SETTLE: begin
          dir_q <= gsp_pkg::DIR_LEFT;
          if (bp_q == goal_q) begin
            found_cost_q <= best_q;
            cur_q        <= goal_q;
            len_q        <= LB'(1);
            state_q      <= ST_LEN_RD;
          end else begin
            state_q <= ST_REL_RD;
          end
        end
        ST_REL_RD: begin
          to_q <= to_pix;
          if (dir_ok) begin
            state_q <= ST_REL_WR;
          end else if (dir_q == gsp_pkg::DIR_DOWN) begin
            state_q <= ST_NEXT;
          end else begin
            dir_q <= dir_q + 2'd1;
          end
        end
        ST_REL_WR: begin
          if (dir_q == gsp_pkg::DIR_DOWN) begin
            state_q <= ST_NEXT;
          end else begin
            dir_q   <= dir_q + 2'd1;
            state_q <= ST_REL_RD;
          end
        end
        ST_LEN_RD: begin
          if (cur_q == '0 || len_q >= n_q) begin
            found_len_q <= len_q;
            idx_q       <= len_q;
            cur_q       <= goal_q;
            state_q     <= ST_PATH_RD;
          end else begin
            state_q <= ST_LEN_WT;
          end
        end
        ST_LEN_WT: begin
          cur_q   <= parent_rdata_q;
          len_q   <= LB'(len_q + LB'(1));
          state_q <= ST_LEN_RD;
        end
        ST_PATH_RD: begin
          state_q <= ST_PATH_WT;
        end
        ST_PATH_WT: begin
          cur_q <= parent_rdata_q;
          idx_q <= LB'(idx_q - LB'(1));
          if (idx_q == LB'(1)) begin
            out_valid_q <= 1'b1;
            status_q    <= 1'b0;
            pixel_q     <= '0;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_PATH_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign fc64          = 64'(found_cost_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign total_cost_o  = (fc64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fc64[31:0];
  assign path_length_o = 13'(found_len_q);
  assign path_pixel_o  = pixel_q;

  // The stored path never outgrows the pixel store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(found_len_q) <= NPIX) else $error("path length beyond pixel store");

  // A relaxation never targets the pixel that was just settled.
  a_rel_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REL_WR |-> to_q != bp_q) else $error("relaxation of settled pixel");

  // A run request holds the input side until its search has finished.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && op_i == gsp_pkg::OP_RUN |=> in_stall_o && !out_valid_q)
    else $error("run request did not hold the input");

endmodule

FILE: sim/grid_shortest_path_engine_test.sv
// Self-checking testbench for grid_shortest_path_engine: loads pixel costs, runs searches on
// many grid shapes and reads the found paths back, checking every response against its own
// path solver. Depends on gsp_pkg and the engine RTL.
`timescale 1ns / 1ps

module grid_shortest_path_engine_test;

  localparam int PIXELS = 4096;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic        status;
    logic [31:0] total_cost;
    logic [12:0] path_length;
    logic [11:0] path_pixel;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [6:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  op_i;
  logic [11:0] pixel_or_position_i;
  logic [15:0] cost_left_i;
  logic [15:0] cost_up_i;
  logic [15:0] cost_right_i;
  logic [15:0] cost_down_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        status_o;
  logic [31:0] total_cost_o;
  logic [12:0] path_length_o;
  logic [11:0] path_pixel_o;

  grid_shortest_path_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .op_i(op_i), .pixel_or_position_i(pixel_or_position_i),
    .cost_left_i(cost_left_i), .cost_up_i(cost_up_i),
    .cost_right_i(cost_right_i), .cost_down_i(cost_down_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .total_cost_o(total_cost_o),
    .path_length_o(path_length_o), .path_pixel_o(path_pixel_o)
  );

  // Solver state, kept in step with every accepted request.
  int          grid_w_raw;
  int          grid_h_raw;
  logic [15:0] step_cost [PIXELS][4];
  bit          cost_loaded [PIXELS];
  logic [31:0] dist_to [PIXELS];
  int          parent_of [PIXELS];
  bit          settled [PIXELS];
  bit          reached [PIXELS];
  int          route [PIXELS];
  int          route_len;
  logic [31:0] route_cost;

  answer_t answers_due[$];
  int      mismatches;
  int      items_sent;
  int      loads_sent;
  int      runs_sent;
  int      reads_sent;
  bit      steady_mode;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int clamp_dim(int v);
    if (v < 1) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  task automatic relax_edge(int from, int to, int dir);
    logic [32:0] sum;
    logic [31:0] cand;
    if (settled[to]) return;
    sum = {1'b0, dist_to[from]} + {17'd0, step_cost[from][dir]};
    cand = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (!reached[to] || cand < dist_to[to]) begin
      reached[to] = 1'b1;
      dist_to[to] = cand;
      parent_of[to] = from;
    end
  endtask

  task automatic solve_grid();
    int  w, h, n, goal, p, x, y, len, cur;
    bit  found;
    w = clamp_dim(grid_w_raw);
    h = clamp_dim(grid_h_raw);
    n = w * h;
    goal = n - 1;
    for (int i = 0; i < PIXELS; i++) begin
      settled[i] = 1'b0;
      reached[i] = 1'b0;
    end
    reached[0] = 1'b1;
    dist_to[0] = '0;
    parent_of[0] = 0;
    forever begin
      found = 1'b0;
      p = 0;
      for (int i = 0; i < n; i++) begin
        if (reached[i] && !settled[i] && (!found || dist_to[i] < dist_to[p])) begin
          p = i;
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[p] = 1'b1;
      if (p == goal) break;
      x = p % w;
      y = p / w;
      if (x > 0) relax_edge(p, p - 1, gsp_pkg::DIR_LEFT);
      if (y > 0) relax_edge(p, p - w, gsp_pkg::DIR_UP);
      if (x + 1 < w) relax_edge(p, p + 1, gsp_pkg::DIR_RIGHT);
      if (y + 1 < h) relax_edge(p, p + w, gsp_pkg::DIR_DOWN);
    end
    route_cost = dist_to[goal];
    len = 1;
    cur = goal;
    while (cur != 0 && len < n) begin
      cur = parent_of[cur];
      len++;
    end
    route_len = len;
    cur = goal;
    for (int i = len; i > 0; i--) begin
      route[i - 1] = cur;
      cur = parent_of[cur];
    end
  endtask

  task automatic apply_request(logic [1:0] op, logic [11:0] pos, logic [15:0] cl,
                               logic [15:0] cu, logic [15:0] cr, logic [15:0] cd,
                               output answer_t ans);
    ans = '0;
    case (op)
      gsp_pkg::OP_LOAD: begin
        step_cost[pos][gsp_pkg::DIR_LEFT]  = cl;
        step_cost[pos][gsp_pkg::DIR_UP]    = cu;
        step_cost[pos][gsp_pkg::DIR_RIGHT] = cr;
        step_cost[pos][gsp_pkg::DIR_DOWN]  = cd;
        cost_loaded[pos] = 1'b1;
      end
      gsp_pkg::OP_RUN: solve_grid();
      gsp_pkg::OP_READ: begin
        if (pos < route_len) ans.path_pixel = route[pos][11:0];
        else ans.status = 1'b1;
      end
      default: ;
    endcase
    ans.total_cost  = route_cost;
    ans.path_length = route_len[12:0];
  endtask

  // Called at a clock edge; leaves valid high after acceptance so the next request
  // can follow back to back.
  task automatic send_request(logic [1:0] op, logic [11:0] pos, logic [15:0] cl,
                              logic [15:0] cu, logic [15:0] cr, logic [15:0] cd);
    answer_t ans;
    int      gap;
    if (!steady_mode && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    op_i                <= op;
    pixel_or_position_i <= pos;
    cost_left_i         <= cl;
    cost_up_i           <= cu;
    cost_right_i        <= cr;
    cost_down_i         <= cd;
    do @(posedge clk_i); while (in_stall_o);
    apply_request(op, pos, cl, cu, cr, cd, ans);
    answers_due.push_back(ans);
    items_sent++;
    case (op)
      gsp_pkg::OP_LOAD: loads_sent++;
      gsp_pkg::OP_RUN:  runs_sent++;
      gsp_pkg::OP_READ: reads_sent++;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic load_pixel(int pix);
    send_request(gsp_pkg::OP_LOAD, pix[11:0], pick_cost(), pick_cost(), pick_cost(),
                 pick_cost());
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, int value);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[6:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == gsp_pkg::CFG_GRID_WIDTH) grid_w_raw = value;
    else grid_h_raw = value;
  endtask

  task automatic set_grid(int w, int h);
    write_reg(gsp_pkg::CFG_GRID_WIDTH, w);
    write_reg(gsp_pkg::CFG_GRID_HEIGHT, h);
  endtask

  // Every pixel of the grid in use gets costs before a search touches it.
  task automatic run_search();
    int n;
    n = clamp_dim(grid_w_raw) * clamp_dim(grid_h_raw);
    for (int i = 0; i < n; i++)
      if (!cost_loaded[i]) load_pixel(i);
    send_request(gsp_pkg::OP_RUN, 12'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
  endtask

  task automatic read_path(int extra);
    int last;
    last = route_len + extra;
    for (int k = 0; k < last; k++) send_request(gsp_pkg::OP_READ, k[11:0], '0, '0, '0, '0);
  endtask

  task automatic test_reads_before_run();
    send_request(gsp_pkg::OP_READ, 12'd0, '0, '0, '0, '0);
    send_request(gsp_pkg::OP_READ, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_SPARE, 12'hABC, 16'h1234, '0, '0, '0);
  endtask

  task automatic test_single_pixel();
    set_grid(0, 1);
    send_request(gsp_pkg::OP_LOAD, 12'd0, 16'd7, 16'd7, 16'd7, 16'd7);
    run_search();
    read_path(1);
    set_grid(1, 0);
    run_search();
    read_path(1);
  endtask

  task automatic test_cost_extremes();
    set_grid(2, 2);
    for (int i = 0; i < 4; i++) send_request(gsp_pkg::OP_LOAD, i[11:0], '1, '1, '1, '1);
    send_request(gsp_pkg::OP_LOAD, 12'hFFF, '1, '0, '1, '0);
    run_search();
    read_path(1);
    // All-zero costs make every step a tie, so the lowest index must settle first.
    for (int i = 0; i < 4; i++) send_request(gsp_pkg::OP_LOAD, i[11:0], '0, '0, '0, '0);
    run_search();
    read_path(1);
    send_request(OP_SPARE, 12'd1, '1, '1, '1, '1);
  endtask

  task automatic test_register_extremes();
    set_grid(127, 1);
    run_search();
    read_path(1);
    // A register change leaves the stored path readable until the next search.
    set_grid(1, 127);
    read_path(1);
    run_search();
    set_grid(64, 1);
    run_search();
    set_grid(8, 8);
    run_search();
    read_path(2);
  endtask

  task automatic test_random_traffic();
    int phase, w, h, n, rounds, loads, reads;
    phase = 0;
    while (items_sent < 530) begin
      steady_mode = (phase >= 2 && phase < 5);
      w = $urandom_range(0, 6);
      h = $urandom_range(0, 6);
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(0, 127);
        h = $urandom_range(0, 1);
      end
      set_grid(w, h);
      n = clamp_dim(w) * clamp_dim(h);
      rounds = $urandom_range(2, 4);
      repeat (rounds) begin
        loads = $urandom_range(1, n);
        repeat (loads) load_pixel($urandom_range(0, n - 1));
        if ($urandom_range(0, 99) < 15) begin
          case ($urandom_range(0, 2))
            0: send_request(OP_SPARE, 12'($urandom), pick_cost(), pick_cost(),
                            pick_cost(), pick_cost());
            1: load_pixel($urandom_range(0, PIXELS - 1));
            default: send_request(gsp_pkg::OP_READ, 12'($urandom), '0, '0, '0, '0);
          endcase
        end
        run_search();
        reads = $urandom_range(1, 4);
        repeat (reads)
          send_request(gsp_pkg::OP_READ, 12'($urandom_range(0, route_len + 1)),
                       '0, '0, '0, '0);
      end
      phase++;
    end
    steady_mode = 1'b0;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0d, got %0d at %0t", name, want, got, $realtime);
    end
  endtask

  always @(posedge clk_i) begin : check_result
    answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("response with no request pending at %0t", $realtime);
      end else begin
        want = answers_due.pop_front();
        check_field("status", want.status, status_o);
        check_field("total_cost", want.total_cost, total_cost_o);
        check_field("path_length", want.path_length, path_length_o);
        check_field("path_pixel", want.path_pixel, path_pixel_o);
      end
    end
  end

  always @(posedge clk_i)
    out_stall_i <= steady_mode ? 1'b0 : ($urandom_range(99) < 36);

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = gsp_pkg::CFG_GRID_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    op_i = gsp_pkg::OP_LOAD;
    pixel_or_position_i = '0;
    cost_left_i = '0;
    cost_up_i = '0;
    cost_right_i = '0;
    cost_down_i = '0;
    out_stall_i = 1'b0;
    steady_mode = 1'b0;
    grid_w_raw = 64;
    grid_h_raw = 64;
    route_len = 0;
    route_cost = '0;
    mismatches = 0;
    items_sent = 0;
    loads_sent = 0;
    runs_sent = 0;
    reads_sent = 0;
    for (int i = 0; i < PIXELS; i++) cost_loaded[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reads_before_run();
    test_single_pixel();
    test_cost_extremes();
    test_register_extremes();
    test_random_traffic();

    wait_for_drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests: %0d loads, %0d searches, %0d path reads,",
             items_sent, loads_sent, runs_sent, reads_sent);
    $display("on grids from one pixel up to 64 pixels, with random stalls on both sides.");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/gsp_pkg.sv
design/grid_shortest_path_engine.sv
sim/grid_shortest_path_engine_test.sv
